>>> rtl/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;
  localparam int NumSlots  = 16;
  localparam int TimeBits  = 32;
  localparam int CountBits = 16;
  localparam int SlotBits  = $clog2(NumSlots);
  localparam int QueueDepth = 2;

  localparam logic [2:0] OpTick    = 3'd0;
  localparam logic [2:0] OpAddOne  = 3'd1;
  localparam logic [2:0] OpAddRec  = 3'd2;
  localparam logic [2:0] OpAddLim  = 3'd3;
  localparam logic [2:0] OpUpdate  = 3'd4;
  localparam logic [2:0] OpCancel  = 3'd5;
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoFree   = 2'd1;
  localparam logic [1:0] StInactive = 2'd2;
  localparam logic [1:0] StNothing  = 2'd3;

  // Classified request handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]           opcode;
    logic [3:0]           slot_number;
    logic [TimeBits-1:0]  time_value;
    logic [CountBits-1:0] repeat_limit;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] slot_id;
    logic [1:0] status;
    logic       final_fire;
    logic       last_of_run;
  } res_t;
endpackage
`default_nettype wire

>>> rtl/mts_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Accepts requests, drops unused opcodes and queues the rest.
module mts_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mts_pkg::req_t in_req_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output mts_pkg::req_t      q_req_o
);
  localparam int PtrBits = $clog2(mts_pkg::QueueDepth);
  mts_pkg::req_t        mem_q [mts_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;
  logic                 push, pop, keep;

  assign keep       = (in_req_i.opcode <= mts_pkg::OpCancel);
  assign in_ready_o = (cnt_q != (PtrBits+1)'(mts_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o && keep;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> rtl/mts_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Executes one queued request; a tick scans the slots one per cycle while the result register can take a result.
module mts_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire mts_pkg::req_t q_req_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output mts_pkg::res_t      res_o
);
  localparam int TB = mts_pkg::TimeBits;
  localparam int CB = mts_pkg::CountBits;
  localparam int SB = mts_pkg::SlotBits;
  localparam int NS = mts_pkg::NumSlots;
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;

  logic [1:0]    state_q, state_d;
  logic [TB-1:0] now_q, now_d;
  logic [NS-1:0] act_q, act_d;
  logic [TB-1:0] dl_q [NS];
  logic [TB-1:0] iv_q [NS];
  logic [CB-1:0] lim_q [NS];
  logic [CB-1:0] fc_q [NS];
  logic [SB-1:0] idx_q, idx_d;
  // A due slot found in the scan is held back until the next due slot or the
  // end of the scan, so the last event can carry last_of_run.
  logic          pend_q, pend_d;
  mts_pkg::res_t pend_r_q, pend_r_d;
  logic          ov_q, ov_d;
  mts_pkg::res_t ov_r_q, ov_r_d;
  // When a scan ends with both a held and a current due slot, the final event
  // goes out after the held one; a flag keeps the scan open for it.
  logic          tail_q, tail_d;

  logic          out_free;
  logic          cmd_fire;
  logic          scan_go;
  logic          fire;
  logic          last_idx;
  logic          zero_lim;
  logic          fr_found;
  logic [SB-1:0] fr_idx;
  logic          sn_ok;
  logic [SB-1:0] sn_idx;
  logic [TB-1:0] tv;
  logic          due;
  logic [CB-1:0] fc_inc;
  logic          hit_lim;
  logic [TB-1:0] diff;
  mts_pkg::res_t cur_r;

  assign out_free    = !ov_q || res_ready_i;
  assign res_valid_o = ov_q;
  assign res_o       = ov_r_q;
  assign q_ready_o   = (state_q == SIdle) && out_free;

  always_comb begin
    fr_found = 1'b0;
    fr_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        fr_found = 1'b1;
        fr_idx   = SB'(i);
      end
    end
  end

  assign sn_ok  = (32'(q_req_i.slot_number) < NS) &&
                  act_q[SB'(q_req_i.slot_number)];
  assign sn_idx = SB'(q_req_i.slot_number);

  assign tv = TB'(q_req_i.time_value);

  assign diff    = now_q - dl_q[idx_q];
  assign due     = act_q[idx_q] && !diff[TB-1];
  assign fc_inc  = fc_q[idx_q] + 1'b1;
  assign hit_lim = (lim_q[idx_q] != '0) && (fc_inc >= lim_q[idx_q]);

  assign cmd_fire = q_ready_o && q_valid_i;
  assign scan_go  = (state_q == SScan) && out_free;
  assign fire     = scan_go && !tail_q && due;
  assign last_idx = (idx_q == SB'(NS - 1));
  assign zero_lim = (q_req_i.opcode == mts_pkg::OpAddLim) && (q_req_i.repeat_limit == '0);
  assign cur_r    = '{1'b1, 4'(idx_q), mts_pkg::StOk, hit_lim, last_idx};

  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    act_d    = act_q;
    idx_d    = idx_q;
    pend_d   = pend_q;
    pend_r_d = pend_r_q;
    ov_d     = ov_q && !res_ready_i;
    ov_r_d   = ov_r_q;
    tail_d   = tail_q;
    if (cmd_fire) begin
      case (q_req_i.opcode)
        mts_pkg::OpTick: begin
          now_d   = now_q + 1'b1;
          state_d = SScan;
          idx_d   = '0;
        end
        mts_pkg::OpAddOne, mts_pkg::OpAddRec, mts_pkg::OpAddLim: begin
          ov_d   = 1'b1;
          ov_r_d = '{1'b0, 4'd0, mts_pkg::StOk, 1'b0, 1'b1};
          if (zero_lim) begin
            ov_r_d.status = mts_pkg::StNothing;
          end else if (!fr_found) begin
            ov_r_d.status = mts_pkg::StNoFree;
          end else begin
            ov_r_d.slot_id = 4'(fr_idx);
            act_d[fr_idx]  = 1'b1;
          end
        end
        mts_pkg::OpUpdate, mts_pkg::OpCancel: begin
          ov_d   = 1'b1;
          ov_r_d = '{1'b0, q_req_i.slot_number, mts_pkg::StOk, 1'b0, 1'b1};
          if (!sn_ok) ov_r_d.status = mts_pkg::StInactive;
          else if (q_req_i.opcode == mts_pkg::OpCancel) act_d[sn_idx] = 1'b0;
        end
        default: ;
      endcase
    end
    if (scan_go) begin
      if (tail_q) begin
        ov_d    = 1'b1;
        ov_r_d  = pend_r_q;
        tail_d  = 1'b0;
        pend_d  = 1'b0;
        state_d = SIdle;
      end else begin
        if (due && (iv_q[idx_q] == '0 || hit_lim)) act_d[idx_q] = 1'b0;
        if (due) begin
          if (pend_q) begin
            ov_d   = 1'b1;
            ov_r_d = pend_r_q;
          end else if (last_idx) begin
            ov_d   = 1'b1;
            ov_r_d = cur_r;
          end
          pend_r_d = cur_r;
        end else if (pend_q && last_idx) begin
          ov_d               = 1'b1;
          ov_r_d             = pend_r_q;
          ov_r_d.last_of_run = 1'b1;
        end
        if (last_idx) begin
          if (due && pend_q) begin
            tail_d = 1'b1;
          end else begin
            pend_d  = 1'b0;
            state_d = SIdle;
          end
        end else begin
          if (due) pend_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ov_r_q   <= ov_r_d;
    pend_r_q <= pend_r_d;
    if (cmd_fire && !zero_lim && fr_found &&
        (q_req_i.opcode inside {mts_pkg::OpAddOne, mts_pkg::OpAddRec, mts_pkg::OpAddLim})) begin
      fc_q[fr_idx] <= '0;
      if (q_req_i.opcode == mts_pkg::OpAddOne) begin
        dl_q[fr_idx]  <= tv;
        iv_q[fr_idx]  <= '0;
        lim_q[fr_idx] <= '0;
      end else begin
        iv_q[fr_idx]  <= tv;
        dl_q[fr_idx]  <= now_q + tv;
        lim_q[fr_idx] <= (q_req_i.opcode == mts_pkg::OpAddLim) ?
                         q_req_i.repeat_limit[CB-1:0] : '0;
      end
    end
    if (cmd_fire && sn_ok && q_req_i.opcode == mts_pkg::OpUpdate) begin
      iv_q[sn_idx] <= tv;
      dl_q[sn_idx] <= now_q + tv;
    end
    if (fire) begin
      if (lim_q[idx_q] != '0) fc_q[idx_q] <= fc_inc;
      dl_q[idx_q] <= now_q + iv_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; now_q <= '0; act_q <= '0; idx_q <= '0;
      pend_q <= 1'b0; ov_q <= 1'b0; tail_q <= 1'b0;
    end else begin
      state_q <= state_d; now_q <= now_d; act_q <= act_d; idx_q <= idx_d;
      pend_q <= pend_d; ov_q <= ov_d; tail_q <= tail_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/multi_slot_timer_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Timer slot scheduler.
// Slave channel s_axis carries one request: opcode, slot_number, time_value
// and repeat_limit packed in tdata. Master channel m_axis returns results:
// tdata holds result_kind, slot_id, status, final_fire; tlast marks the
// last result of a request.
// A command (add, update, cancel) gives one response; it passes the front queue
// and a result register, and waits in the queue while the execution unit is busy.
// A tick advances time and scans the sixteen slots one per cycle while
// results drain, holds the execution unit until the scan ends, and emits
// one expiry event per due slot; a tick with nothing due gives no result.
// Opcodes six and seven are dropped in the front queue.
// The two-entry request queue lets requests be taken while a tick scans.
// When the receiver stalls, the scan holds at its current slot and the
// queue fills, then s_axis_tready drops.
// Reset clears time and frees every slot.
module multi_slot_timer_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], slot_number[6:3], time_value[38:7], repeat_limit[54:39]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_kind[0], slot_id[4:1], status[6:5], final_fire[7]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);
  mts_pkg::req_t in_req, q_req;
  mts_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_req = '{s_axis_tdata[2:0], s_axis_tdata[6:3], s_axis_tdata[38:7],
                    s_axis_tdata[54:39]};

  mts_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_req_i(in_req), .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );

  mts_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {res.final_fire, res.status, res.slot_id, res.result_kind};
  assign m_axis_tlast = res.last_of_run;

  // A command response never carries the final flag and always sets tlast.
  a_resp_no_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> !m_axis_tdata[7] && m_axis_tlast)
    else $error("response with final flag");
  // Expiry events always report ok.
  a_exp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6:5] == mts_pkg::StOk)
    else $error("expiry with error status");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> sim/timer_sched_checker.sv
`timescale 1ns / 1ps
module timer_sched_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending_count
);
  logic [mts_pkg::TimeBits-1:0]  now_ms;
  logic                          busy    [mts_pkg::NumSlots];
  logic [mts_pkg::TimeBits-1:0]  due_at  [mts_pkg::NumSlots];
  logic [mts_pkg::TimeBits-1:0]  period  [mts_pkg::NumSlots];
  logic [mts_pkg::CountBits-1:0] fire_cap[mts_pkg::NumSlots];
  logic [mts_pkg::CountBits-1:0] fired   [mts_pkg::NumSlots];
  mts_pkg::res_t                 awaited_results[$];

  function automatic mts_pkg::res_t make_result(logic kind, logic [3:0] slot,
                                                logic [1:0] st, logic fin);
    mts_pkg::res_t r;
    r.result_kind = kind;
    r.slot_id     = slot;
    r.status      = st;
    r.final_fire  = fin;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic queue_result(input mts_pkg::res_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  // Applies one accepted request to the shadow timer table and queues its results.
  task automatic schedule_request(input logic [55:0] d);
    logic [2:0]                    op;
    logic [3:0]                    sn;
    logic [mts_pkg::TimeBits-1:0]  tv;
    logic [mts_pkg::CountBits-1:0] rl;
    logic [mts_pkg::TimeBits-1:0]  diff;
    logic                          fin, kill;
    int                            n, s;
    op = d[2:0];
    sn = d[6:3];
    tv = d[38:7];
    rl = d[54:39];
    n  = 0;
    s  = -1;
    case (op)
      mts_pkg::OpTick: begin
        now_ms = now_ms + 1;
        for (int i = 0; i < mts_pkg::NumSlots; i++) begin
          diff = now_ms - due_at[i];
          if (busy[i] && !diff[mts_pkg::TimeBits-1]) begin
            fin  = 1'b0;
            kill = (period[i] == 0);
            if (fire_cap[i] != 0) begin
              fired[i] = fired[i] + 1;
              if (fired[i] >= fire_cap[i]) begin
                kill = 1'b1;
                fin  = 1'b1;
              end
            end
            if (kill) busy[i] = 1'b0;
            else due_at[i] = now_ms + period[i];
            queue_result(make_result(1'b1, 4'(i), mts_pkg::StOk, fin));
            n++;
          end
        end
      end
      mts_pkg::OpAddOne, mts_pkg::OpAddRec, mts_pkg::OpAddLim: begin
        n = 1;
        if (op == mts_pkg::OpAddLim && rl == 0) begin
          queue_result(make_result(1'b0, 4'd0, mts_pkg::StNothing, 1'b0));
        end else begin
          for (int i = mts_pkg::NumSlots - 1; i >= 0; i--) if (!busy[i]) s = i;
          if (s < 0) begin
            queue_result(make_result(1'b0, 4'd0, mts_pkg::StNoFree, 1'b0));
          end else begin
            busy[s]  = 1'b1;
            fired[s] = '0;
            if (op == mts_pkg::OpAddOne) begin
              due_at[s]   = tv;
              period[s]   = '0;
              fire_cap[s] = '0;
            end else begin
              period[s]   = tv;
              due_at[s]   = now_ms + tv;
              fire_cap[s] = (op == mts_pkg::OpAddLim) ? rl : '0;
            end
            queue_result(make_result(1'b0, 4'(s), mts_pkg::StOk, 1'b0));
          end
        end
      end
      mts_pkg::OpUpdate, mts_pkg::OpCancel: begin
        n = 1;
        if (!busy[sn]) begin
          queue_result(make_result(1'b0, sn, mts_pkg::StInactive, 1'b0));
        end else begin
          if (op == mts_pkg::OpUpdate) begin
            period[sn] = tv;
            due_at[sn] = now_ms + tv;
          end else begin
            busy[sn] = 1'b0;
          end
          queue_result(make_result(1'b0, sn, mts_pkg::StOk, 1'b0));
        end
      end
      default: ;
    endcase
    if (n > 0) awaited_results[$].last_of_run = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mts_pkg::res_t got, want;
    if (!rst_ni) begin
      now_ms     = '0;
      fail_count = 0;
      for (int i = 0; i < mts_pkg::NumSlots; i++) busy[i] = 1'b0;
      awaited_results.delete();
      pending_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[6:5], m_axis_tdata[7],
               m_axis_tlast};
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, actual %p", want, got);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) schedule_request(s_axis_tdata);
      pending_count = awaited_results.size();
    end
  end
endmodule

>>> sim/tb_multi_slot_timer_scheduler.sv
`timescale 1ns / 1ps
module tb_multi_slot_timer_scheduler;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // opcode[2:0], slot_number[6:3], time_value[38:7], repeat_limit[54:39]
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // result_kind[0], slot_id[4:1], status[6:5], final_fire[7]
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  int          fail_count, pending_count;
  int          cycle_count = 0;

  multi_slot_timer_scheduler dut (.*);

  timer_sched_checker checker_i (.*);

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls in runs; sometimes long open stretches.
  int stall_left = 0, open_left = 0;
  always @(posedge clk_i) begin
    if (open_left > 0) begin
      open_left <= open_left - 1;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 8);
      else open_left <= $urandom_range(0, 40);
    end
  end

  function automatic logic [55:0] pack_request(logic [2:0] op, logic [3:0] sn,
                                               logic [31:0] tv, logic [15:0] rl);
    return {1'b0, rl, tv, sn, op};
  endfunction

  task automatic send_request(input logic [55:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [55:0] random_request();
    logic [2:0]  op;
    logic [31:0] tv;
    logic [15:0] rl;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = mts_pkg::OpTick;
    else if (pick < 55) op = mts_pkg::OpAddOne;
    else if (pick < 65) op = mts_pkg::OpAddRec;
    else if (pick < 77) op = mts_pkg::OpAddLim;
    else if (pick < 86) op = mts_pkg::OpUpdate;
    else if (pick < 96) op = mts_pkg::OpCancel;
    else op = ($urandom_range(0, 1) == 0) ? mts_pkg::OpSpareLo : mts_pkg::OpSpareHi;
    // Mostly short times so timers actually fire; sometimes full range.
    tv = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 6);
    rl = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (op == mts_pkg::OpAddOne && tv[31:4] == 0) tv = tv + 32'($urandom_range(0, 8)) - 32'd4;
    return pack_request(op, 4'($urandom), tv, rl);
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: inactive slots, zero limit, past deadline, zero interval, table full.
    send_request(pack_request(mts_pkg::OpCancel, 4'd15, 32'd0, 16'd0));
    send_request(pack_request(mts_pkg::OpUpdate, 4'd0, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(pack_request(mts_pkg::OpAddLim, 4'd0, 32'd1, 16'd0));
    send_request(pack_request(mts_pkg::OpSpareLo, 4'd3, 32'd5, 16'd5));
    send_request(pack_request(mts_pkg::OpSpareHi, 4'd3, 32'd5, 16'd5));
    send_request(pack_request(mts_pkg::OpAddOne, 4'd0, 32'hFFFF_FFFF, 16'd0));
    send_request(pack_request(mts_pkg::OpAddRec, 4'd0, 32'd0, 16'd0));
    send_request(pack_request(mts_pkg::OpAddLim, 4'd0, 32'd1, 16'd2));
    send_request(pack_request(mts_pkg::OpAddLim, 4'd0, 32'h7FFF_FFFF, 16'hFFFF));
    send_request(pack_request(mts_pkg::OpTick, 4'd0, 32'd0, 16'd0));
    send_request(pack_request(mts_pkg::OpUpdate, 4'd3, 32'h8000_0000, 16'd0));
    send_request(pack_request(mts_pkg::OpTick, 4'd15, 32'hFFFF_FFFF, 16'hFFFF));
    send_request(pack_request(mts_pkg::OpCancel, 4'd3, 32'd0, 16'd0));
    for (int i = 0; i < 16; i++)
      send_request(pack_request(mts_pkg::OpAddOne, 4'd0, 32'd2, 16'd0));
    send_request(pack_request(mts_pkg::OpAddRec, 4'd0, 32'd1, 16'd1));
    send_request(pack_request(mts_pkg::OpTick, 4'd0, 32'd0, 16'd0));
    send_request(pack_request(mts_pkg::OpTick, 4'd0, 32'd0, 16'd0));
    for (int i = 0; i < 220; i++) begin
      send_request(random_request());
      pause_sender();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
